// ----- sv/binary_min_heap_queue_macros.svh -----
// Assertion helpers for binary_min_heap_queue
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define BMHQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bmhq assertion failed");
`define BMHQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmhq assertion failed");
`else
`define BMHQ_ASSERT(lbl, prop)
`define BMHQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/bmhq_pkg.sv -----
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        count_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    value_t x;
  } cell_cmd_t;

  typedef struct packed {
    value_t val;
    logic   vld;
    logic   keep;
  } cell_link_t;

  typedef struct packed {
    value_t val;
    logic   vld;
  } cell_nxt_t;

endpackage

// ----- sv/bmhq_cell.sv -----
`timescale 1ns / 1ps

module bmhq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  bmhq_pkg::cell_cmd_t  cmd,
  input  bmhq_pkg::cell_link_t left,
  input  bmhq_pkg::cell_link_t right,
  output bmhq_pkg::cell_link_t link,
  output bmhq_pkg::cell_nxt_t  nxt
);

  bmhq_pkg::value_t val_r;
  bmhq_pkg::value_t val_nxt;
  logic             vld_r;
  logic             vld_nxt;
  logic             keep;

  // cells stay sorted ascending; an entry stays put if it is not larger than the new value
  assign keep = vld_r && !(cmd.x < val_r);

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (cmd.ins) begin
      if (!keep) begin
        val_nxt = left.keep ? cmd.x : left.val;
      end
      vld_nxt = vld_r | left.vld;
    end else if (cmd.rem) begin
      val_nxt = right.val;
      vld_nxt = right.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link.val  = val_r;
  assign link.vld  = vld_r;
  assign link.keep = keep;
  assign nxt.val   = val_nxt;
  assign nxt.vld   = vld_nxt;

endmodule

// ----- sv/binary_min_heap_queue.sv -----
`timescale 1ns / 1ps

// Min priority queue of up to 64 signed 32-bit values. Entries live in a row of
// compare-and-shift cells kept in ascending order, so the minimum always sits in
// the first cell. An insert is compared against every cell at once and the larger
// entries step one cell to the right; a remove steps every entry one cell to the
// left. Each transaction is applied in the clock that accepts it and its result
// (minimum, count, status) appears from the output register on the next cycle.
// in_ready is high whenever that register is empty or being drained, giving one
// transaction per clock while out_ready is held high. Inserting into a full queue is refused
// with status 2; removing from an empty queue reports status 1 and changes nothing.

`include "binary_min_heap_queue_macros.svh"

module binary_min_heap_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [bmhq_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bmhq_pkg::VAL_W-1:0]   out_front_value,
  output logic                                out_front_valid,
  output logic [bmhq_pkg::CNT_W-1:0]          out_entry_count,
  output logic [bmhq_pkg::STATUS_W-1:0]       out_status
);

  bmhq_pkg::cell_link_t link    [bmhq_pkg::CAPACITY];
  bmhq_pkg::cell_link_t left_in [bmhq_pkg::CAPACITY];
  bmhq_pkg::cell_link_t right_in[bmhq_pkg::CAPACITY];
  bmhq_pkg::cell_nxt_t  nxt     [bmhq_pkg::CAPACITY];
  logic [bmhq_pkg::CAPACITY-1:0] vld_vec;

  bmhq_pkg::cell_cmd_t  cmd;
  bmhq_pkg::count_t     cnt_r;
  bmhq_pkg::count_t     cnt_nxt;
  logic                 in_fire;
  logic                 full;
  logic                 empty;
  logic [bmhq_pkg::STATUS_W-1:0] status;

  logic                          out_valid_r;
  bmhq_pkg::value_t              front_value_r;
  logic                          front_valid_r;
  bmhq_pkg::count_t              entry_count_r;
  logic [bmhq_pkg::STATUS_W-1:0] status_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (cnt_r == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY));
  assign empty    = (cnt_r == '0);

  assign cmd.ins = in_fire && (in_op == bmhq_pkg::OP_INSERT) && !full;
  assign cmd.rem = in_fire && (in_op == bmhq_pkg::OP_REMOVE) && !empty;
  assign cmd.x   = in_value;

  always_comb begin
    if (in_op == bmhq_pkg::OP_INSERT && full) begin
      status = bmhq_pkg::ST_FULL;
    end else if (in_op == bmhq_pkg::OP_REMOVE && empty) begin
      status = bmhq_pkg::ST_EMPTY;
    end else begin
      status = bmhq_pkg::ST_OK;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + bmhq_pkg::CNT_W'(1);
    end else if (cmd.rem) begin
      cnt_nxt = cnt_r - bmhq_pkg::CNT_W'(1);
    end
  end

  genvar i;
  generate
    for (i = 0; i < bmhq_pkg::CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign left_in[i] = '{val: '0, vld: 1'b1, keep: 1'b1};
      end else begin : g_mid
        assign left_in[i] = link[i-1];
      end
      if (i == bmhq_pkg::CAPACITY - 1) begin : g_tail
        assign right_in[i] = '{val: '0, vld: 1'b0, keep: 1'b0};
      end else begin : g_body
        assign right_in[i] = link[i+1];
      end
      assign vld_vec[i] = link[i].vld;

      bmhq_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .left  (left_in[i]),
        .right (right_in[i]),
        .link  (link[i]),
        .nxt   (nxt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      front_value_r <= nxt[0].vld ? nxt[0].val : '0;
      front_valid_r <= nxt[0].vld;
      entry_count_r <= cnt_nxt;
      status_r      <= status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = front_value_r;
  assign out_front_valid = front_valid_r;
  assign out_entry_count = entry_count_r;
  assign out_status      = status_r;

  `BMHQ_ASSERT(a_count_matches_cells, ($countones(vld_vec) == int'(cnt_r)))
  `BMHQ_ASSERT_NEXT(a_full_refused, in_fire && in_op == bmhq_pkg::OP_INSERT && full, out_status == bmhq_pkg::ST_FULL && cnt_r == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
  `BMHQ_ASSERT_NEXT(a_empty_remove, in_fire && in_op == bmhq_pkg::OP_REMOVE && empty, out_status == bmhq_pkg::ST_EMPTY && cnt_r == '0 && !out_front_valid)
  `BMHQ_ASSERT(a_front_tracks_count, (!out_valid || (out_front_valid == (out_entry_count != '0))))

endmodule

// ----- verif/binary_min_heap_queue_tb.sv -----
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;

  typedef struct {
    bmhq_pkg::value_t              front_value;
    logic                          front_valid;
    bmhq_pkg::count_t              entry_count;
    logic [bmhq_pkg::STATUS_W-1:0] status;
  } pq_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_op = bmhq_pkg::OP_INSERT;
  bmhq_pkg::value_t              in_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  bmhq_pkg::value_t              out_front_value;
  logic                          out_front_valid;
  bmhq_pkg::count_t              out_entry_count;
  logic [bmhq_pkg::STATUS_W-1:0] out_status;

  bmhq_pkg::value_t pq_heap [bmhq_pkg::CAPACITY];
  int               pq_count;
  pq_result_t       pending_results [$];
  int               mismatch_count = 0;
  bit               no_idle = 1'b0;

  binary_min_heap_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_front_value (out_front_value),
    .out_front_valid (out_front_valid),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // heap predictor: applies one transaction, returns the expected result
  function automatic pq_result_t pq_apply(logic op, bmhq_pkg::value_t v);
    pq_result_t       r;
    int               idx;
    int               up;
    int               pos;
    int               lc;
    int               rc;
    int               pick;
    bmhq_pkg::value_t tmp;
    r.status = bmhq_pkg::ST_OK;
    if (op == bmhq_pkg::OP_INSERT) begin
      if (pq_count >= bmhq_pkg::CAPACITY) begin
        r.status = bmhq_pkg::ST_FULL;
      end else begin
        pq_heap[pq_count] = v;
        idx = pq_count;
        pq_count++;
        while (idx != 0) begin
          up = (idx - 1) / 2;
          if (pq_heap[idx] < pq_heap[up]) begin
            tmp = pq_heap[idx];
            pq_heap[idx] = pq_heap[up];
            pq_heap[up] = tmp;
            idx = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (pq_count == 0) begin
        r.status = bmhq_pkg::ST_EMPTY;
      end else begin
        pq_count--;
        pq_heap[0] = pq_heap[pq_count];
        pos = 0;
        forever begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (rc < pq_count) begin
            pick = (pq_heap[lc] < pq_heap[rc]) ? lc : rc;
          end else if (lc < pq_count) begin
            pick = lc;
          end else begin
            break;
          end
          if (pq_heap[pick] < pq_heap[pos]) begin
            tmp = pq_heap[pos];
            pq_heap[pos] = pq_heap[pick];
            pq_heap[pick] = tmp;
            pos = pick;
          end else begin
            break;
          end
        end
      end
    end
    r.front_valid = (pq_count != 0);
    r.front_value = (pq_count != 0) ? pq_heap[0] : '0;
    r.entry_count = bmhq_pkg::count_t'(pq_count);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result(pq_result_t exp_r);
    if (out_front_value !== exp_r.front_value)
      report_mismatch($sformatf("front_value %0d, want %0d", out_front_value,
                                exp_r.front_value));
    if (out_front_valid !== exp_r.front_valid)
      report_mismatch($sformatf("front_valid %0b, want %0b", out_front_valid,
                                exp_r.front_valid));
    if (out_entry_count !== exp_r.entry_count)
      report_mismatch($sformatf("entry_count %0d, want %0d", out_entry_count,
                                exp_r.entry_count));
    if (out_status !== exp_r.status)
      report_mismatch($sformatf("status %0d, want %0d", out_status, exp_r.status));
  endtask

  // predict on accepted input, then check any accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_results.push_back(pq_apply(in_op, in_value));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0)
          report_mismatch("result transaction with nothing pending");
        else
          check_result(pending_results.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 10);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic op, bmhq_pkg::value_t v);
    if (!no_idle && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic test_empty_remove();
    send_item(bmhq_pkg::OP_REMOVE, $urandom);
  endtask

  task automatic test_extreme_values();
    send_item(bmhq_pkg::OP_INSERT, 32'sh7fffffff);
    send_item(bmhq_pkg::OP_INSERT, 32'sh80000000);
    send_item(bmhq_pkg::OP_INSERT, 32'sh00000000);
    send_item(bmhq_pkg::OP_INSERT, -32'sd1);
    send_item(bmhq_pkg::OP_INSERT, 32'sd1);
    send_item(bmhq_pkg::OP_INSERT, 32'sh2aaaaaaa);
  endtask

  task automatic test_equal_values();
    send_item(bmhq_pkg::OP_INSERT, 32'sd5);
    send_item(bmhq_pkg::OP_INSERT, 32'sd5);
    send_item(bmhq_pkg::OP_INSERT, -32'sd3);
    send_item(bmhq_pkg::OP_INSERT, -32'sd3);
    send_item(bmhq_pkg::OP_INSERT, 32'sd5);
  endtask

  // one more remove than stored entries, ending on an empty-queue remove
  task automatic test_drain_to_empty();
    repeat (12) send_item(bmhq_pkg::OP_REMOVE, $urandom);
  endtask

  function automatic bmhq_pkg::value_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return bmhq_pkg::value_t'($urandom);
      4, 5, 6:    return bmhq_pkg::value_t'($urandom_range(0, 15)) - 32'sd8;
      7:          return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default:    return bmhq_pkg::value_t'($urandom) | 32'sh80000000;
    endcase
  endfunction

  // phases of fill, drain and mixed traffic so the queue hits full and empty
  task automatic test_random_traffic();
    int  pct_insert;
    for (int n = 0; n < 850; n++) begin
      no_idle = (n >= 300 && n < 450);
      case ((n / 100) % 4)
        0, 3:    pct_insert = 85;
        1:       pct_insert = 15;
        default: pct_insert = 50;
      endcase
      if ($urandom_range(0, 99) < pct_insert)
        send_item(bmhq_pkg::OP_INSERT, pick_value());
      else
        send_item(bmhq_pkg::OP_REMOVE, bmhq_pkg::value_t'($urandom));
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
  endtask

  initial begin
    pq_count = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_remove();
    test_extreme_values();
    test_equal_values();
    test_drain_to_empty();
    test_random_traffic();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("binary_min_heap_queue_tb passed");
    end else begin
      $display("binary_min_heap_queue_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("binary_min_heap_queue_tb failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/bmhq_pkg.sv
sv/bmhq_cell.sv
sv/binary_min_heap_queue.sv
verif/binary_min_heap_queue_tb.sv
